// ----- design/button_debounce_autorepeat_macros.svh -----
// ----------------------------------------------------------------------------
// Button debounce assertion macros
// Shared concurrent assertion wrappers; compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_AUTOREPEAT_MACROS_SVH
`define BUTTON_DEBOUNCE_AUTOREPEAT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked property, disabled while reset is high.
`define BDA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Checked property that also holds during reset.
`define BDA_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed");

`else

`define BDA_ASSERT(lbl, clk, rst, prop)
`define BDA_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ----- design/bda_pkg.sv -----
// ----------------------------------------------------------------------------
// Button debounce package
// Types and constants shared by the debounce state machine and the top level.
// ----------------------------------------------------------------------------
package bda_pkg;

   localparam int PAD_W      = 3;
   localparam int NOW_W      = 32;
   localparam int CFG_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 8;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT   = 2'd2;

   // Register reset values in milliseconds.
   localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
   localparam logic [CFG_W-1:0] HOLD_RST     = 16'd800;
   localparam logic [CFG_W-1:0] REPEAT_RST   = 16'd200;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_BOUNCE  = 2'd1,
      PH_PRESSED = 2'd2
   } phase_type;

   typedef struct packed {
      logic [CFG_W-1:0] debounce_ms;
      logic [CFG_W-1:0] hold_ms;
      logic [CFG_W-1:0] repeat_ms;
   } cfg_type;

endpackage

// ----- design/bda_fsm.sv -----
// ----------------------------------------------------------------------------
// Button debounce state machine
// Holds the phase and timestamps and works out the key for one sample.
// ----------------------------------------------------------------------------
`include "button_debounce_autorepeat_macros.svh"

module bda_fsm
   import bda_pkg::*;
#(
   parameter int TIME_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  logic [PAD_W-1:0]      pad_value,
   input  logic [TIME_WIDTH-1:0] now_t,
   input  cfg_type               cfg,
   output logic [PAD_W-1:0]      key_value
);

   phase_type             phase_ff, phase_in;
   logic [TIME_WIDTH-1:0] bounce_start_ff, bounce_start_in;
   logic [TIME_WIDTH-1:0] hold_start_ff, hold_start_in;
   logic [TIME_WIDTH-1:0] repeat_last_ff, repeat_last_in;
   logic [PAD_W-1:0]      latched_ff, latched_in;
   logic                  held_ff, held_in;

   logic debounce_done, hold_done, repeat_done;

   // Subtraction at TIME_WIDTH bits wraps exactly like the timestamp counter.
   assign debounce_done = (now_t - bounce_start_ff) >= TIME_WIDTH'(cfg.debounce_ms);
   assign hold_done     = (now_t - hold_start_ff) >= TIME_WIDTH'(cfg.hold_ms);
   assign repeat_done   = (now_t - repeat_last_ff) >= TIME_WIDTH'(cfg.repeat_ms);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         bounce_start_ff <= '0;
         hold_start_ff   <= '0;
         repeat_last_ff  <= '0;
         latched_ff      <= '0;
         held_ff         <= 1'b0;
      end else if (step_en) begin
         phase_ff        <= phase_in;
         bounce_start_ff <= bounce_start_in;
         hold_start_ff   <= hold_start_in;
         repeat_last_ff  <= repeat_last_in;
         latched_ff      <= latched_in;
         held_ff         <= held_in;
      end
   end

   always_comb begin
      phase_in        = phase_ff;
      bounce_start_in = bounce_start_ff;
      hold_start_in   = hold_start_ff;
      repeat_last_in  = repeat_last_ff;
      latched_in      = latched_ff;
      held_in         = held_ff;
      key_value       = '0;
      case (phase_ff)
         PH_BOUNCE: begin
            // Samples inside the bounce window are ignored.
            if (debounce_done) begin
               if (pad_value != '0) begin
                  phase_in      = PH_PRESSED;
                  hold_start_in = now_t;
                  latched_in    = pad_value;
                  key_value     = pad_value;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
         end
         PH_PRESSED: begin
            if (pad_value == '0) begin
               phase_in        = PH_BOUNCE;
               bounce_start_in = now_t;
               held_in         = 1'b0;
            end else if (pad_value == latched_ff) begin
               if (!held_ff) begin
                  if (hold_done) begin
                     held_in        = 1'b1;
                     repeat_last_in = now_t;
                     key_value      = pad_value;
                  end
               end else if (repeat_done) begin
                  repeat_last_in = now_t;
                  key_value      = pad_value;
               end
            end
         end
         default: begin
            // Idle, and the unused phase code behaves the same.
            phase_in = PH_IDLE;
            if (pad_value != '0) begin
               phase_in        = PH_BOUNCE;
               bounce_start_in = now_t;
            end
         end
      endcase
   end

   `BDA_ASSERT_ALWAYS(a_held_only_pressed, clock,
      held_ff |-> (phase_ff == PH_PRESSED))
   `BDA_ASSERT(a_key_leaves_pressed, clock, reset,
      (step_en && key_value != '0) |=> (phase_ff == PH_PRESSED))
   `BDA_ASSERT(a_key_is_latched, clock, reset,
      (step_en && key_value != '0) |=> (latched_ff == $past(key_value)))

endmodule

// ----- design/button_debounce_autorepeat.sv -----
// ----------------------------------------------------------------------------
// Button debounce with auto-repeat
// Debounces a 3-bit button pad and repeats a held key at a set interval.
// ----------------------------------------------------------------------------
// Each req transfer carries one pad sample and its millisecond timestamp; each
// one produces exactly one rsp transfer carrying the qualified key, where zero
// means no key this sample. A press is emitted once it has settled for
// debounce_ms, again after hold_ms of holding, then every repeat_ms.
// The result of a sample accepted at one edge is valid after that edge.
// Throughput is one sample per cycle while rsp does not stall, set by the
// single state update between the request and the result register.
// A stalled rsp side holds the result register; a new sample is still taken
// in the cycle the waiting result is transferred, and req_tready drops only
// while a result is held and rsp_tready is low.
// Reset clears the state to idle, empties the result register and loads the
// timing registers with 50, 800 and 200 ms. The user must write the csr port
// only while no sample is in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
`include "button_debounce_autorepeat_macros.svh"

module button_debounce_autorepeat
   import bda_pkg::*;
#(
   parameter int TIME_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // pad_value[2:0], now_ms[34:3]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // key_value[2:0]
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]      csr_wdata
);

   cfg_type               cfg_ff;
   logic                  rsp_valid_ff;
   logic [PAD_W-1:0]      rsp_key_ff;
   logic                  req_fire;
   logic [PAD_W-1:0]      pad_value;
   logic [TIME_WIDTH-1:0] now_t;
   logic [PAD_W-1:0]      key_value;

   assign pad_value = req_tdata[PAD_W-1:0];
   assign now_t     = TIME_WIDTH'(req_tdata[PAD_W+NOW_W-1:PAD_W]);

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms <= DEBOUNCE_RST;
         cfg_ff.hold_ms     <= HOLD_RST;
         cfg_ff.repeat_ms   <= REPEAT_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DEBOUNCE: cfg_ff.debounce_ms <= csr_wdata;
            CSR_HOLD:     cfg_ff.hold_ms     <= csr_wdata;
            CSR_REPEAT:   cfg_ff.repeat_ms   <= csr_wdata;
            default:      ;
         endcase
      end
   end

   bda_fsm #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_fsm (
      .clock     (clock),
      .reset     (reset),
      .step_en   (req_fire),
      .pad_value (pad_value),
      .now_t     (now_t),
      .cfg       (cfg_ff),
      .key_value (key_value)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_key_ff <= key_value;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-PAD_W){1'b0}}, rsp_key_ff};

   `BDA_ASSERT(a_accept_gives_result, clock, reset,
      req_fire |=> rsp_valid_ff)
   `BDA_ASSERT(a_no_accept_while_stalled, clock, reset,
      (rsp_valid_ff && !rsp_tready) |-> !req_fire)

endmodule
